FILE: sv/nmet_pkg.sv
package nmet_pkg;

  localparam int MomentumBitsDef = 24;
  localparam int CordicStepsDef  = 16;
  localparam int AtanTableLen    = 24;
  localparam int SumW            = 32;
  localparam int ProdW           = 64;
  localparam int CordicW         = 36;
  localparam int SqrtSteps       = 32;
  localparam int CntW            = 5;
  localparam int AngleW          = 16;

  localparam logic [31:0] HalfTurn    = 32'h8000_0000;
  localparam logic [31:0] AngleRound  = 32'h0000_8000;
  localparam logic [63:0] SqrtBitInit = 64'h4000_0000_0000_0000;
  localparam logic [7:0]  StatusFinal = 8'd1;

  localparam logic signed [31:0] CodeNuE      = 32'sd12;
  localparam logic signed [31:0] CodeNuMu     = 32'sd14;
  localparam logic signed [31:0] CodeNuTau    = 32'sd16;
  localparam logic signed [31:0] CodeNuEBar   = -32'sd12;
  localparam logic signed [31:0] CodeNuMuBar  = -32'sd14;
  localparam logic signed [31:0] CodeNuTauBar = -32'sd16;

  typedef struct packed {
    logic signed [SumW-1:0] x;
    logic signed [SumW-1:0] y;
  } nmet_sums_t;

  typedef enum logic [2:0] {
    StIdle,
    StMulX,
    StMulY,
    StRun,
    StFinish
  } nmet_state_e;

  function automatic logic is_neutrino(input logic signed [31:0] code);
    return (code == CodeNuE) || (code == CodeNuEBar) || (code == CodeNuMu) ||
           (code == CodeNuMuBar) || (code == CodeNuTau) || (code == CodeNuTauBar);
  endfunction

  function automatic logic signed [SumW-1:0] sat_add(input logic signed [SumW-1:0] acc,
                                                     input logic signed [SumW-1:0] v);
    logic signed [SumW:0] s;
    s = {acc[SumW-1], acc} + {v[SumW-1], v};
    if (s[SumW] != s[SumW-1]) begin
      return s[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
    end
    return s[SumW-1:0];
  endfunction

  function automatic logic [31:0] atan_phase(input logic [CntW-1:0] idx);
    logic [31:0] r;
    unique case (idx)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/nmet_intf.sv
interface nmet_in_if #(
  parameter int MomBits = 24
);
  logic                      valid;
  logic                      ready;
  logic [7:0]                particle_status;
  logic signed [31:0]        particle_code;
  logic signed [MomBits-1:0] mom_x;
  logic signed [MomBits-1:0] mom_y;
  logic                      last_in_event;

  modport source (
    output valid, particle_status, particle_code, mom_x, mom_y, last_in_event,
    input  ready
  );
  modport sink (
    input  valid, particle_status, particle_code, mom_x, mom_y, last_in_event,
    output ready
  );
endinterface

interface nmet_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] met_magnitude;
  logic [15:0] met_angle;

  modport source (
    output valid, met_magnitude, met_angle,
    input  ready
  );
  modport sink (
    input  valid, met_magnitude, met_angle,
    output ready
  );
endinterface

FILE: sv/nmet_front.sv
module nmet_front
  import nmet_pkg::*;
#(
  parameter int MomBits = MomentumBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  nmet_in_if.sink      in_i,
  output logic         push_o,
  output nmet_sums_t   sums_o,
  input  logic         full_i
);

  logic signed [SumW-1:0]    sum_x_q, sum_x_d;
  logic signed [SumW-1:0]    sum_y_q, sum_y_d;
  logic                      accept;
  logic                      counts;
  logic signed [MomBits-1:0] mom_x;
  logic signed [MomBits-1:0] mom_y;
  logic signed [SumW-1:0]    add_x;
  logic signed [SumW-1:0]    add_y;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && in_i.ready;
  assign counts     = (in_i.particle_status == StatusFinal) && is_neutrino(in_i.particle_code);
  assign mom_x      = in_i.mom_x[MomBits-1:0];
  assign mom_y      = in_i.mom_y[MomBits-1:0];

  always_comb begin
    add_x  = counts ? sat_add(sum_x_q, SumW'(mom_x)) : sum_x_q;
    add_y  = counts ? sat_add(sum_y_q, SumW'(mom_y)) : sum_y_q;
    sums_o = '{x: add_x, y: add_y};
    push_o = accept && in_i.last_in_event;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    if (accept) begin
      sum_x_d = in_i.last_in_event ? '0 : add_x;
      sum_y_d = in_i.last_in_event ? '0 : add_y;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_x_q <= '0;
      sum_y_q <= '0;
    end else begin
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
    end
  end

  a_skip_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !counts && !in_i.last_in_event |=> $stable(sum_x_q) && $stable(sum_y_q))
    else $error("Sums changed on a particle that does not count.");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (sum_x_q == '0) && (sum_y_q == '0))
    else $error("Sums not cleared after the last particle of an event.");

  a_push_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> in_i.valid && in_i.ready && in_i.last_in_event)
    else $error("Event pushed without an accepted last particle.");

endmodule

FILE: sv/nmet_fifo.sv
module nmet_fifo
  import nmet_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  nmet_sums_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output nmet_sums_t pop_data_o
);

  nmet_sums_t mem_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = count_q[1];
  assign empty_o    = (count_q == 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Event queue written while full.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("Event queue read while empty.");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3)
    else $error("Event queue count out of range.");

endmodule

FILE: sv/nmet_back.sv
module nmet_back
  import nmet_pkg::*;
#(
  parameter int CordicSteps = CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  nmet_sums_t sums_i,
  output logic       pop_o,
  nmet_out_if.source res_o
);

  localparam int CordicN = (CordicSteps > AtanTableLen) ? AtanTableLen : CordicSteps;

  nmet_state_e st_q, st_d;

  logic [31:0]               ax_q, ax_d;
  logic [31:0]               ay_q, ay_d;
  logic [ProdW-1:0]          n_q, n_d;
  logic [ProdW-1:0]          root_q, root_d;
  logic [ProdW-1:0]          bit_q, bit_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic signed [CordicW-1:0] cx_q, cx_d;
  logic signed [CordicW-1:0] cy_q, cy_d;
  logic [31:0]               z_q, z_d;
  logic                      cen_q, cen_d;
  logic                      res_valid_q, res_valid_d;
  logic [31:0]               res_mag_q, res_mag_d;
  logic [AngleW-1:0]         res_ang_q, res_ang_d;

  logic [ProdW-1:0]          sq_x;
  logic [ProdW-1:0]          sq_y;
  logic [ProdW-1:0]          trial;
  logic signed [CordicW-1:0] sx_ext;
  logic signed [CordicW-1:0] sy_ext;
  logic signed [CordicW-1:0] dx;
  logic signed [CordicW-1:0] dy;
  logic [31:0]               phase;
  logic                      out_free;

  assign sq_x     = ax_q * ax_q;
  assign sq_y     = ay_q * ay_q;
  assign trial    = root_q + bit_q;
  assign sx_ext   = CordicW'(sums_i.x);
  assign sy_ext   = CordicW'(sums_i.y);
  assign dx       = cy_q >>> cnt_q;
  assign dy       = cx_q >>> cnt_q;
  assign phase    = z_q + HalfTurn + AngleRound;
  assign out_free = !res_valid_q || res_o.ready;

  always_comb begin
    st_d        = st_q;
    ax_d        = ax_q;
    ay_d        = ay_q;
    n_d         = n_q;
    root_d      = root_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    z_d         = z_q;
    cen_d       = cen_q;
    res_mag_d   = res_mag_q;
    res_ang_d   = res_ang_q;
    res_valid_d = res_valid_q && !res_o.ready;
    pop_o       = 1'b0;

    unique case (st_q)
      StIdle: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          ax_d  = sums_i.x[SumW-1] ? (~sums_i.x + 32'd1) : sums_i.x;
          ay_d  = sums_i.y[SumW-1] ? (~sums_i.y + 32'd1) : sums_i.y;
          cx_d  = sx_ext;
          cy_d  = sy_ext;
          z_d   = '0;
          cen_d = 1'b1;
          if (sums_i.y == '0) begin
            cen_d = 1'b0;
            z_d   = sums_i.x[SumW-1] ? HalfTurn : '0;
          end else if (sums_i.x[SumW-1]) begin
            cx_d = -sx_ext;
            cy_d = -sy_ext;
            z_d  = HalfTurn;
          end
          st_d = StMulX;
        end
      end
      StMulX: begin
        n_d  = sq_x;
        st_d = StMulY;
      end
      StMulY: begin
        n_d    = n_q + sq_y;
        root_d = '0;
        bit_d  = SqrtBitInit;
        cnt_d  = '0;
        st_d   = StRun;
      end
      StRun: begin
        if (n_q >= trial) begin
          n_d    = n_q - trial;
          root_d = (root_q >> 1) + bit_q;
        end else begin
          root_d = root_q >> 1;
        end
        bit_d = bit_q >> 2;
        if (cen_q && ({1'b0, cnt_q} < (CntW + 1)'(CordicN))) begin
          if (!cy_q[CordicW-1]) begin
            cx_d = cx_q + dx;
            cy_d = cy_q - dy;
            z_d  = z_q + atan_phase(cnt_q);
          end else begin
            cx_d = cx_q - dx;
            cy_d = cy_q + dy;
            z_d  = z_q - atan_phase(cnt_q);
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntW'(SqrtSteps - 1)) begin
          st_d = StFinish;
        end
      end
      StFinish: begin
        if (out_free) begin
          res_valid_d = 1'b1;
          res_mag_d   = root_q[31:0];
          res_ang_d   = phase[31:16];
          st_d        = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      res_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q      <= ax_d;
    ay_q      <= ay_d;
    n_q       <= n_d;
    root_q    <= root_d;
    bit_q     <= bit_d;
    cnt_q     <= cnt_d;
    cx_q      <= cx_d;
    cy_q      <= cy_d;
    z_q       <= z_d;
    cen_q     <= cen_d;
    res_mag_q <= res_mag_d;
    res_ang_q <= res_ang_d;
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.met_magnitude = res_mag_q;
  assign res_o.met_angle     = res_ang_q;

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StRun) && (cnt_q == CntW'(SqrtSteps - 1)) |=> st_q == StFinish)
    else $error("Square root pass did not end after its last step.");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == StFinish) && out_free |=> res_valid_q && (st_q == StIdle))
    else $error("Finished event did not reach the result register.");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> st_q == StMulX)
    else $error("Event taken from the queue without starting the product.");

endmodule

FILE: sv/neutrino_missing_et_sum.sv
// Particles are accepted one per cycle unless the event queue is full; each is
// classified and summed on arrival, and the last one's sums enter the queue.
// The result unit takes one event at a time and runs a 32-step square root loop.
// A two-entry event queue stalls the input only when both entries are waiting.
// Reset is asynchronous and active low; it clears the sums, queue and result valid.
module neutrino_missing_et_sum
  import nmet_pkg::*;
#(
  parameter int MOMENTUM_BITS = MomentumBitsDef,
  parameter int CORDIC_STEPS  = CordicStepsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  nmet_in_if.sink    in_i,
  nmet_out_if.source res_o
);

  logic       push;
  logic       full;
  logic       pop;
  logic       empty;
  nmet_sums_t push_data;
  nmet_sums_t pop_data;

  nmet_front #(
    .MomBits (MOMENTUM_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .sums_o (push_data),
    .full_i (full)
  );

  nmet_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  nmet_back #(
    .CordicSteps (CORDIC_STEPS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .sums_i  (pop_data),
    .pop_o   (pop),
    .res_o   (res_o)
  );

endmodule

FILE: verif/neutrino_missing_et_sum_tb.sv
module neutrino_missing_et_sum_tb;
  import nmet_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int     CycleLimit  = 400000;
  localparam int     DrainCycles = 120;
  localparam int     RandomItems = 80;
  localparam int     HoldCycles  = 1500;
  localparam longint SumMax      = 64'sh0000_0000_7FFF_FFFF;
  localparam longint SumMin      = -64'sh0000_0000_8000_0000;

  localparam logic signed [MomentumBitsDef-1:0] MomMax = 24'sh7F_FFFF;
  localparam logic signed [MomentumBitsDef-1:0] MomMin = 24'sh80_0000;

  localparam logic [15:0] StallPattern = 16'b1011_0011_1110_0101;

  localparam logic [AtanTableLen*32-1:0] AtanTurns = {
    32'd81, 32'd163, 32'd326, 32'd652, 32'd1304, 32'd2608,
    32'd5215, 32'd10430, 32'd20861, 32'd41722, 32'd83443, 32'd166886,
    32'd333772, 32'd667544, 32'd1335087, 32'd2670163, 32'd5340245, 32'd10679838,
    32'd21354465, 32'd42667331, 32'd85004756, 32'd167458907, 32'd316933406,
    32'd536870912
  };

  typedef enum logic [1:0] {
    SinkOpen,
    SinkRandom,
    SinkPattern
  } sink_mode_e;

  typedef struct {
    logic [7:0]                         status;
    logic signed [31:0]                 code;
    logic signed [MomentumBitsDef-1:0]  mx;
    logic signed [MomentumBitsDef-1:0]  my;
    logic                               last;
  } particle_t;

  typedef struct {
    logic [31:0] mag;
    logic [15:0] ang;
  } met_t;

  logic clk_i;
  logic rst_ni;

  nmet_in_if #(.MomBits(MomentumBitsDef)) part_if ();
  nmet_out_if                             met_if ();

  neutrino_missing_et_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (part_if),
    .res_o  (met_if)
  );

  logic signed [31:0] acc_px;
  logic signed [31:0] acc_py;
  met_t               met_pending[$];
  met_t               met_want;
  int                 err_cnt     = 0;
  int                 cycle_cnt   = 0;
  int                 src_gap_max = 0;
  int                 burst_left  = 0;
  int                 hold_left   = 0;
  sink_mode_e         sink_mode   = SinkOpen;
  logic [3:0]         pat_idx     = '0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("neutrino_missing_et_sum_tb: done, errors");
      $finish;
    end
  end

  function automatic logic is_nu_code(input logic signed [31:0] code);
    return code == CodeNuE || code == CodeNuEBar || code == CodeNuMu ||
           code == CodeNuMuBar || code == CodeNuTau || code == CodeNuTauBar;
  endfunction

  function automatic logic signed [31:0] clamp_add(input logic signed [31:0] acc,
                                                   input logic signed [MomentumBitsDef-1:0] v);
    longint s;
    s = longint'(acc) + longint'(v);
    if (s > SumMax) s = SumMax;
    if (s < SumMin) s = SumMin;
    return s[31:0];
  endfunction

  function automatic logic [31:0] vector_turn(input longint x, input longint y);
    logic [31:0] z;
    longint      dx;
    longint      dy;
    z = '0;
    if (x == 0 && y == 0) return '0;
    if (y == 0) return (x > 0) ? 32'd0 : HalfTurn;
    if (x < 0) begin
      x = -x;
      y = -y;
      z = HalfTurn;
    end
    for (int i = 0; i < CordicStepsDef && i < AtanTableLen; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x = x + dx;
        y = y - dy;
        z = z + AtanTurns[i*32 +: 32];
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - AtanTurns[i*32 +: 32];
      end
    end
    return z;
  endfunction

  function automatic met_t met_of_sums(input logic signed [31:0] sx,
                                       input logic signed [31:0] sy);
    met_t        m;
    longint      x;
    longint      y;
    logic [63:0] sq;
    logic [63:0] trial_sq;
    logic [31:0] root;
    logic [31:0] trial;
    logic [31:0] ph;
    x = sx;
    y = sy;
    sq = 64'(x * x) + 64'(y * y);
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (32'd1 << b);
      trial_sq = {32'd0, trial} * {32'd0, trial};
      if (trial_sq <= sq) root = trial;
    end
    ph = vector_turn(x, y) + HalfTurn;
    ph = ph + AngleRound;
    m.mag = root;
    m.ang = ph[31:16];
    return m;
  endfunction

  function automatic void fold_particle(input particle_t p);
    if (p.status == StatusFinal && is_nu_code(p.code)) begin
      acc_px = clamp_add(acc_px, p.mx);
      acc_py = clamp_add(acc_py, p.my);
    end
    if (p.last) begin
      met_pending.insert(met_pending.size(), met_of_sums(acc_px, acc_py));
      acc_px = '0;
      acc_py = '0;
    end
  endfunction

  function automatic particle_t pack_particle(input logic [7:0] status,
                                              input logic signed [31:0] code,
                                              input logic signed [MomentumBitsDef-1:0] mx,
                                              input logic signed [MomentumBitsDef-1:0] my,
                                              input logic last);
    particle_t p;
    p.status = status;
    p.code   = code;
    p.mx     = mx;
    p.my     = my;
    p.last   = last;
    return p;
  endfunction

  function automatic logic signed [31:0] pick_nu_code();
    case ($urandom_range(0, 5))
      0:       return CodeNuE;
      1:       return CodeNuEBar;
      2:       return CodeNuMu;
      3:       return CodeNuMuBar;
      4:       return CodeNuTau;
      default: return CodeNuTauBar;
    endcase
  endfunction

  function automatic logic signed [MomentumBitsDef-1:0] rand_mom();
    int          sel;
    int          v;
    logic [31:0] raw;
    sel = $urandom_range(0, 99);
    raw = $urandom();
    if (sel < 55) begin
      v = int'($urandom_range(0, 20000)) - 10000;
      return v[MomentumBitsDef-1:0];
    end
    if (sel < 93) return raw[MomentumBitsDef-1:0];
    if (sel < 96) return MomMax;
    if (sel < 99) return MomMin;
    return '0;
  endfunction

  function automatic particle_t rand_particle(input logic last);
    particle_t p;
    p = pack_particle(StatusFinal, pick_nu_code(), rand_mom(), rand_mom(), last);
    if ($urandom_range(0, 99) < 25) begin
      case ($urandom_range(0, 3))
        0: begin
          p.status = 8'($urandom_range(0, 255));
          p.code   = $urandom();
        end
        1: p.status = $urandom_range(0, 1) ? 8'($urandom_range(2, 255)) : 8'd0;
        2: p.code = pick_nu_code() + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        default: begin
          p.status = 8'($urandom_range(0, 255));
          p.code   = pick_nu_code() ^ (32'sd1 << $urandom_range(4, 31));
        end
      endcase
    end
    return p;
  endfunction

  task automatic send_particle(input particle_t p);
    int gap;
    @(negedge clk_i);
    part_if.valid           <= 1'b1;
    part_if.particle_status <= p.status;
    part_if.particle_code   <= p.code;
    part_if.mom_x           <= p.mx;
    part_if.mom_y           <= p.my;
    part_if.last_in_event   <= p.last;
    @(posedge clk_i);
    while (!part_if.ready) @(posedge clk_i);
    fold_particle(p);
    if (src_gap_max != 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, src_gap_max);
        @(negedge clk_i);
        part_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic source_idle();
    @(negedge clk_i);
    part_if.valid <= 1'b0;
  endtask

  task automatic test_empty_events();
    sink_mode   = SinkOpen;
    src_gap_max = 0;
    send_particle(pack_particle(8'd2, CodeNuE, MomMax, MomMin, 1'b0));
    send_particle(pack_particle(8'd0, CodeNuMuBar, 24'sd500, 24'sd500, 1'b0));
    send_particle(pack_particle(StatusFinal, 32'sd13, 24'sd77, -24'sd9, 1'b0));
    send_particle(pack_particle(8'd255, 32'sh8000_0000, -24'sd1, -24'sd1, 1'b1));
    send_particle(pack_particle(StatusFinal, 32'sh7FFF_FFFF, MomMin, MomMax, 1'b1));
    source_idle();
  endtask

  task automatic test_flavors();
    sink_mode   = SinkPattern;
    src_gap_max = 3;
    send_particle(pack_particle(StatusFinal, CodeNuE, 24'sd100, 24'sd0, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuEBar, -24'sd100, 24'sd0, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuMu, 24'sd0, MomMax, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuMuBar, 24'sd0, MomMin, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuTau, MomMax, MomMax, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuTauBar, MomMin, MomMin, 1'b1));
    source_idle();
  endtask

  task automatic test_quadrants();
    sink_mode   = SinkRandom;
    src_gap_max = 0;
    send_particle(pack_particle(StatusFinal, CodeNuE, 24'sd5, 24'sd7, 1'b0));
    send_particle(pack_particle(StatusFinal, CodeNuMuBar, -24'sd5, -24'sd7, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuTau, -24'sd3, 24'sd4, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuEBar, 24'sd3, -24'sd4, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuMu, -24'sd1, -24'sd1, 1'b1));
    send_particle(pack_particle(StatusFinal, CodeNuTauBar, -24'sd1, 24'sd1, 1'b0));
    send_particle(pack_particle(8'd3, CodeNuE, 24'sd999, 24'sd999, 1'b1));
    source_idle();
  endtask

  task automatic test_saturation();
    sink_mode   = SinkRandom;
    src_gap_max = 0;
    for (int k = 0; k < 258; k++) begin
      send_particle(pack_particle(StatusFinal, CodeNuMu, MomMax, MomMin, 1'b0));
    end
    send_particle(pack_particle(StatusFinal, CodeNuE, MomMin, MomMax, 1'b1));
    source_idle();
  endtask

  task automatic test_random_events();
    int        counted;
    int        n;
    particle_t p;
    counted = 0;
    while (counted < RandomItems) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       src_gap_max = 0;
          1:       src_gap_max = 4;
          default: src_gap_max = 45;
        endcase
        sink_mode = sink_mode_e'($urandom_range(0, 2));
      end
      for (int k = 0; k < n; k++) begin
        p = rand_particle(k == n - 1);
        counted++;
        send_particle(p);
      end
    end
    source_idle();
  endtask

  task automatic test_backpressure();
    int n;
    sink_mode   = SinkOpen;
    src_gap_max = 0;
    hold_left   = HoldCycles;
    for (int e = 0; e < 24; e++) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        send_particle(rand_particle(k == n - 1));
      end
    end
    source_idle();
  endtask

  initial begin
    met_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        met_if.ready <= 1'b0;
        hold_left--;
      end else begin
        case (sink_mode)
          SinkOpen:   met_if.ready <= 1'b1;
          SinkRandom: met_if.ready <= ($urandom_range(0, 99) < 60);
          default: begin
            met_if.ready <= StallPattern[pat_idx];
            pat_idx++;
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && met_if.valid && met_if.ready) begin
      if (met_pending.size() == 0) begin
        $display("%0t: unexpected transaction, expected none, actual magnitude %0d angle %0d",
                 $time, met_if.met_magnitude, met_if.met_angle);
        err_cnt++;
      end else begin
        met_want = met_pending.pop_front();
        if (met_if.met_magnitude !== met_want.mag) begin
          $display("%0t: magnitude mismatch, expected %0d, actual %0d",
                   $time, met_want.mag, met_if.met_magnitude);
          err_cnt++;
        end
        if (met_if.met_angle !== met_want.ang) begin
          $display("%0t: angle mismatch, expected %0d, actual %0d",
                   $time, met_want.ang, met_if.met_angle);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    rst_ni                  = 1'b0;
    part_if.valid           = 1'b0;
    part_if.particle_status = '0;
    part_if.particle_code   = '0;
    part_if.mom_x           = '0;
    part_if.mom_y           = '0;
    part_if.last_in_event   = 1'b0;
    acc_px                  = '0;
    acc_py                  = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_events();
    test_flavors();
    test_quadrants();
    test_saturation();
    test_random_events();
    test_backpressure();

    while (met_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("neutrino_missing_et_sum_tb: done, clean");
    end else begin
      $display("neutrino_missing_et_sum_tb: done, errors");
    end
    $finish;
  end

endmodule
